// ===== rtl/core/trp_pkg.sv =====
// Shared types and constants of the triggered record and playback block.
// No dependencies; imported by triggered_record_playback.
package trp_pkg;

    // Sample buffer geometry
    localparam int BUF_DEPTH = 2048;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int POS_W     = ADDR_W + 1;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int DUTY_W   = 8;
    localparam int MODE_W   = 2;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;

    // Width that holds both a position and a configured length
    localparam int LEN_W = (CFG_W > POS_W) ? CFG_W : POS_W;

    // Duty is the stored sample shifted right by this amount
    localparam int DUTY_SHIFT = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = CFG_IDX_W'(1);

    // Configuration reset values
    localparam logic [CFG_W-1:0] THRESHOLD_RST = CFG_W'(1000);
    localparam logic [CFG_W-1:0] LENGTH_RST    = CFG_W'(2000);

    // Operating mode, also the encoding of the mode output
    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE = 2'd0,
        MODE_REC  = 2'd1,
        MODE_PLAY = 2'd2
    } t_mode;

    // What the result stage does with the held duty value
    typedef enum logic [1:0] {
        DUTY_HOLD,
        DUTY_LOAD,
        DUTY_ZERO
    } t_duty_op;

endpackage

// ===== rtl/core/triggered_record_playback.sv =====
// Triggered record and playback block: trigger, sample buffer and PWM duty output.
// Depends on trp_pkg for types and constants.
//
// The block takes one 12-bit sample per item and returns one result per item
// (duty, mode, led). It accepts an item in every cycle unless both stages
// are full. The first stage updates the mode and buffer positions and does
// the single buffer access of the item (one write while recording, one read
// while playing, on a single-port 2048 x 12 memory with registered read
// data); the second stage forms the duty from the read data and holds the
// result until it is taken. Stalling the output stops intake only when both
// stages are full. The buffer needs no clearing after reset. Configuration
// is written through a separate port that is always ready; write it only
// while no item is in flight.
module triggered_record_playback
    import trp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,

    // Sample input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [SAMPLE_W-1:0]  i_sample,

    // Result output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DUTY_W-1:0]    o_duty,
    output logic [MODE_W-1:0]    o_mode,
    output logic                 o_led
);

    // Configuration registers
    logic [CFG_W-1:0]    r_threshold;
    logic [CFG_W-1:0]    r_length;

    // Control state
    t_mode               r_mode;
    t_mode               n_mode;
    logic [POS_W-1:0]    r_write_pos;
    logic [POS_W-1:0]    n_write_pos;
    logic [POS_W-1:0]    r_read_pos;
    logic [POS_W-1:0]    n_read_pos;
    logic                r_led;

    // Sample buffer
    logic [SAMPLE_W-1:0] mem [BUF_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_addr;

    // First stage
    logic                r_s1_valid;
    t_duty_op            r_s1_op;
    t_duty_op            n_s1_op;
    t_mode               r_s1_mode;
    logic                r_s1_led;

    // Result stage
    logic                r_out_valid;
    logic [DUTY_W-1:0]   r_duty;
    logic [DUTY_W-1:0]   n_duty;
    t_mode               r_out_mode;
    logic                r_out_led;

    logic                in_accept;
    logic                s1_move;
    logic [LEN_W-1:0]    eff_len;
    t_mode               cur_mode;
    logic [POS_W-1:0]    start_wpos;
    logic [LEN_W-1:0]    wpos_ext;
    logic [LEN_W-1:0]    rpos_ext;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign s1_move     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !s1_move;
    assign in_accept   = i_in_valid && !o_in_stall;

    // Take configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_length    <= LENGTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_LENGTH:    r_length    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the configured length to one .. buffer depth
    always_comb begin
        if (r_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (LEN_W'(r_length) > LEN_W'(BUF_DEPTH)) begin
            eff_len = LEN_W'(BUF_DEPTH);
        end else begin
            eff_len = LEN_W'(r_length);
        end
    end

    // Next state: trigger, then recording or playback positions
    always_comb begin
        cur_mode    = r_mode;
        start_wpos  = r_write_pos;
        n_mode      = r_mode;
        n_write_pos = r_write_pos;
        n_read_pos  = r_read_pos;
        wpos_ext    = '0;
        rpos_ext    = '0;

        // Any mode other than recording or playback acts as idle
        if (r_mode != MODE_REC && r_mode != MODE_PLAY) begin
            cur_mode = MODE_IDLE;
            if (i_sample > r_threshold) begin
                cur_mode   = MODE_REC;
                start_wpos = '0;
            end
        end
        n_mode = cur_mode;

        unique case (cur_mode)
            MODE_REC: begin
                if (start_wpos < POS_W'(BUF_DEPTH)) begin
                    n_write_pos = start_wpos + POS_W'(1);
                end else begin
                    n_write_pos = POS_W'(eff_len);
                end
                wpos_ext = LEN_W'(n_write_pos);
                if (wpos_ext >= eff_len) begin
                    n_mode     = MODE_PLAY;
                    n_read_pos = '0;
                end
            end
            MODE_PLAY: begin
                if (r_read_pos < POS_W'(BUF_DEPTH)) begin
                    n_read_pos = r_read_pos + POS_W'(1);
                end else begin
                    n_read_pos = POS_W'(eff_len);
                end
                rpos_ext = LEN_W'(n_read_pos);
                if (rpos_ext >= eff_len) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: ;
        endcase
    end

    // Outputs of the control step: buffer access and duty update
    always_comb begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = start_wpos[ADDR_W-1:0];
        n_s1_op  = DUTY_HOLD;

        unique case (cur_mode)
            MODE_REC: begin
                mem_we = in_accept && (start_wpos < POS_W'(BUF_DEPTH));
            end
            MODE_PLAY: begin
                mem_addr = r_read_pos[ADDR_W-1:0];
                if (r_read_pos < POS_W'(BUF_DEPTH)) begin
                    mem_re  = in_accept;
                    n_s1_op = DUTY_LOAD;
                end else begin
                    n_s1_op = DUTY_ZERO;
                end
                // Last played entry drives the duty back to zero
                if (n_mode == MODE_IDLE) begin
                    n_s1_op = DUTY_ZERO;
                end
            end
            default: ;
        endcase
    end

    // Advance control state on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_write_pos <= '0;
            r_read_pos  <= '0;
            r_led       <= 1'b0;
        end else if (in_accept) begin
            r_mode      <= n_mode;
            r_write_pos <= n_write_pos;
            r_read_pos  <= n_read_pos;
            r_led       <= !r_led;
        end
    end

    // Single-port buffer with registered read data
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= i_sample;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    // First stage: hold the item until the result stage frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op   <= n_s1_op;
            r_s1_mode <= n_mode;
            r_s1_led  <= !r_led;
        end
    end

    // Form the duty; a 12-bit sample shifted by four always fits eight bits
    always_comb begin
        unique case (r_s1_op)
            DUTY_LOAD: n_duty = DUTY_W'(r_rd_data >> DUTY_SHIFT);
            DUTY_ZERO: n_duty = '0;
            default:   n_duty = r_duty;
        endcase
    end

    // Result stage: load from the first stage, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_duty      <= '0;
        end else begin
            if (s1_move) begin
                r_out_valid <= 1'b1;
                r_duty      <= n_duty;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_mode <= r_s1_mode;
            r_out_led  <= r_s1_led;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_duty      = r_duty;
    assign o_mode      = r_out_mode;
    assign o_led       = r_out_led;

    // Duty is nonzero only while playing
    a_duty_zero_off_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mode != MODE_PLAY) |-> (r_duty == '0))
        else $error("duty nonzero outside playback");

    // Recording position stays inside the buffer
    a_wpos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_REC) |-> (r_write_pos < POS_W'(BUF_DEPTH)))
        else $error("write position beyond buffer while recording");

    // The waiting first-stage item is the latest accepted one
    a_s1_led_latest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1_led == r_led))
        else $error("first stage does not hold the latest item");

    // A stalled result stage with a full first stage blocks intake
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |=> $stable(r_led))
        else $error("item taken while both stages were full");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for triggered_record_playback: trigger, record, playback and LED.
// Depends on trp_pkg and the triggered_record_playback RTL; nothing else.
`timescale 1ns / 100ps

module tb_top;
    import trp_pkg::*;

    localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_LEN    = 300;
    localparam int RANDOM_ITEMS    = 400;
    localparam int LONG_RECORD_LEN = 500;
    localparam int MAX_REPORTS     = 40;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [MODE_W-1:0] mode;
        logic              led;
    } t_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [SAMPLE_W-1:0]  i_sample;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [DUTY_W-1:0]    o_duty;
    logic [MODE_W-1:0]    o_mode;
    logic                 o_led;

    // Playback predictor state
    t_mode               pb_mode;
    int                  pb_wr_pos;
    int                  pb_rd_pos;
    int                  pb_filled;
    logic [SAMPLE_W-1:0] pb_store [BUF_DEPTH];
    logic [DUTY_W-1:0]   pb_duty;
    logic                pb_led;
    logic [CFG_W-1:0]    pb_threshold;
    logic [CFG_W-1:0]    pb_length;

    t_result pending_results[$];

    int items_sent;
    int results_checked;
    int recordings;
    int playbacks_done;
    int cfg_writes;
    int mismatches;
    int quiet_cycles;
    int send_gap_pct;
    int stall_pct;
    int hold_request;

    triggered_record_playback DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_duty      (o_duty),
        .o_mode      (o_mode),
        .o_led       (o_led)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Zero acts as one, anything past the buffer acts as the buffer size
    function automatic int effective_len(input logic [CFG_W-1:0] len);
        int l;
        l = int'(len);
        if (l == 0) l = 1;
        if (l > BUF_DEPTH) l = BUF_DEPTH;
        return l;
    endfunction

    // Advance the predicted recorder by one sample and return its result
    function automatic t_result next_playback_result(input logic [SAMPLE_W-1:0] smp);
        t_result r;
        int      len;
        int      level;
        len   = effective_len(pb_length);
        level = 0;
        pb_led = ~pb_led;
        if (pb_mode != MODE_REC && pb_mode != MODE_PLAY) begin
            pb_mode = MODE_IDLE;
            if (smp > pb_threshold) begin
                pb_mode   = MODE_REC;
                pb_wr_pos = 0;
                recordings++;
            end
        end
        if (pb_mode == MODE_REC) begin
            if (pb_wr_pos < BUF_DEPTH) begin
                pb_store[pb_wr_pos] = smp;
                pb_wr_pos++;
                if (pb_wr_pos > pb_filled) pb_filled = pb_wr_pos;
            end else begin
                pb_wr_pos = len;
            end
            if (pb_wr_pos >= len) begin
                pb_mode   = MODE_PLAY;
                pb_rd_pos = 0;
            end
        end else if (pb_mode == MODE_PLAY) begin
            if (pb_rd_pos < BUF_DEPTH) begin
                level = int'(pb_store[pb_rd_pos]) >> DUTY_SHIFT;
                pb_rd_pos++;
            end else begin
                pb_rd_pos = len;
            end
            if (level > 255) level = 255;
            pb_duty = DUTY_W'(level);
            if (pb_rd_pos >= len) begin
                pb_mode = MODE_IDLE;
                pb_duty = '0;
                playbacks_done++;
            end
        end
        r.duty = pb_duty;
        r.mode = pb_mode;
        r.led  = pb_led;
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    // While idle, mostly offer a trigger; otherwise any sample
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        if (pb_mode == MODE_IDLE) begin
            if (int'(pb_threshold) < SAMPLE_MAX && $urandom_range(0, 99) < 70)
                return SAMPLE_W'($urandom_range(SAMPLE_MAX, int'(pb_threshold) + 1));
            return SAMPLE_W'($urandom_range(int'(pb_threshold), 0));
        end
        return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    endfunction

    // Mostly short recordings, with the zero and one corners now and then
    function automatic logic [CFG_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return CFG_W'(1);
        if (r < 70) return CFG_W'($urandom_range(2, 16));
        if (r < 93) return CFG_W'($urandom_range(17, 64));
        return CFG_W'($urandom_range(65, 300));
    endfunction

    // Never let playback run into entries that were never recorded
    function automatic logic [CFG_W-1:0] fit_length(input logic [CFG_W-1:0] len);
        if (pb_mode == MODE_PLAY && effective_len(len) > pb_filled) return CFG_W'(pb_filled);
        return len;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Offer one sample, optionally after a gap, and predict its result on acceptance
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = ($urandom_range(0, 99) < send_gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= smp;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(next_playback_result(smp));
        items_sent++;
    endtask

    // Drop valid, wait for every pending result, then let the pipeline settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back once the block is quiet
    task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] len);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data  <= thr;
        do @(posedge i_clk); while (!o_cfg_ready);
        pb_threshold = thr;
        i_cfg_index <= CFG_LENGTH;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        pb_length = len;
        i_cfg_valid <= 1'b0;
        cfg_writes += 2;
    endtask

    // Run the current session out until the block is idle again
    task automatic finish_session();
        while (pb_mode != MODE_IDLE) send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
    endtask

    // Threshold extremes, a sample equal to the threshold, length one
    task automatic test_trigger_threshold();
        set_config('0, CFG_W'(1));
        send_sample('0);
        send_sample(SAMPLE_W'(1));
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        set_config(CFG_W'(SAMPLE_MAX), CFG_W'(1));
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample('0);
        set_config(CFG_W'(2000), CFG_W'(1));
        send_sample(SAMPLE_W'(2000));
        send_sample(SAMPLE_W'(2001));
        send_sample('0);
    endtask

    // Length zero acts as one; shortest real recording with full-scale duty
    task automatic test_length_limits();
        set_config(CFG_W'(1000), '0);
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample(SAMPLE_W'(7));
        set_config(CFG_W'(1000), CFG_W'(2));
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample(SAMPLE_W'('h555));
        send_sample('0);
        send_sample('0);
    endtask

    // Shorten during recording and playback, lengthen during playback
    task automatic test_length_change_mid_phase();
        set_config(CFG_W'(1000), CFG_W'(8));
        send_sample(SAMPLE_W'(3000));
        send_sample(SAMPLE_W'('haaa));
        send_sample(SAMPLE_W'('h123));
        set_config(CFG_W'(1000), CFG_W'(2));
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample(SAMPLE_W'(10));
        set_config(CFG_W'(1000), CFG_W'(1));
        send_sample(SAMPLE_W'(20));
        set_config(CFG_W'(1000), CFG_W'(3));
        send_sample(SAMPLE_W'(4000));
        send_sample(SAMPLE_W'(4001));
        send_sample(SAMPLE_W'(4002));
        send_sample(SAMPLE_W'(30));
        // entry three still holds the earlier recording; play it and go idle
        set_config(CFG_W'(1000), CFG_W'(4));
        send_sample(SAMPLE_W'(40));
        send_sample(SAMPLE_W'(50));
        send_sample(SAMPLE_W'(60));
    endtask

    // Hold the output long enough that both stages fill and intake stalls
    task automatic test_output_hold_off();
        set_config(CFG_W'(500), CFG_W'(20));
        send_gap_pct = 0;
        hold_request = HOLD_OFF_LEN;
        repeat (60) send_sample(pick_sample());
        send_gap_pct = 25;
    endtask

    // Random sessions with random settings, some written mid-recording or mid-playback
    task automatic test_random_sessions();
        int stop_at;
        int burst;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            send_gap_pct = pick_idle_pct();
            stall_pct    = pick_idle_pct();
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0: set_config('0, fit_length(pick_length()));
                    1: set_config(CFG_W'(SAMPLE_MAX), fit_length(pick_length()));
                    default: set_config(CFG_W'($urandom_range(0, SAMPLE_MAX - 1)),
                                        fit_length(pick_length()));
                endcase
            end
            burst = $urandom_range(5, 80);
            repeat (burst) send_sample(pick_sample());
        end
        send_gap_pct = 10;
        stall_pct    = 10;
    endtask

    // A length past the buffer keeps recording; then one long session end to end
    task automatic test_long_recordings();
        finish_session();
        set_config(CFG_W'(100), CFG_W'(BUF_DEPTH + 1));
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        repeat (40) send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
        set_config(CFG_W'(100), CFG_W'(30));
        finish_session();
        set_config(CFG_W'(100), CFG_W'(LONG_RECORD_LEN));
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        finish_session();
    endtask

    // Receiver: random stalls, or one long hold-off when a test asks for it
    initial begin : output_stall_gen
        int stall_left;
        int hold_len;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_len     = hold_request;
                hold_request = 0;
                stall_left   = 0;
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
                    stall_left = pick_gap();
                if (stall_left > 0) begin
                    i_out_stall <= 1'b1;
                    stall_left--;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Compare each taken result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result (duty)", o_duty, 0);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_duty !== want.duty) report_mismatch("duty", o_duty, want.duty);
                if (o_mode !== want.mode) report_mismatch("mode", o_mode, want.mode);
                if (o_led !== want.led) report_mismatch("led", o_led, want.led);
            end
        end
    end

    // End the run if no handshake of any kind happens for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles, %0d results outstanding",
                     $realtime, quiet_cycles, pending_results.size());
            $display("** triggered_record_playback: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_sample    <= '0;
        pb_mode      = MODE_IDLE;
        pb_wr_pos    = 0;
        pb_rd_pos    = 0;
        pb_filled    = 0;
        pb_duty      = '0;
        pb_led       = 1'b0;
        pb_threshold = THRESHOLD_RST;
        pb_length    = LENGTH_RST;
        send_gap_pct = 25;
        stall_pct    = 25;
        hold_request = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_trigger_threshold();
        test_length_limits();
        test_length_change_mid_phase();
        test_output_hold_off();
        test_random_sessions();
        test_long_recordings();
        wait_drained();

        $display("Sent %0d samples, checked %0d results, %0d register writes.",
                 items_sent, results_checked, cfg_writes);
        $display("Saw %0d recordings start and %0d playbacks run to the end.",
                 recordings, playbacks_done);
        if (mismatches == 0) begin
            $display("** triggered_record_playback: PASSED **");
        end else begin
            $display("** triggered_record_playback: FAILED **");
        end
        $finish;
    end

endmodule
